// ===== src/countdown_timer_bank_assert.svh =====
// assertion macros for the countdown timer bank
// used by countdown_timer_bank.sv; compiled out when SYNTHESIS is defined
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH
`ifndef SYNTHESIS
`define CTB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("countdown_timer_bank assertion failed");
`define CTB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("countdown_timer_bank assertion failed");
`else
`define CTB_ASSERT(lbl, clk, rst_n, prop)
`define CTB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/ctb_pkg.sv =====
// shared types and constants of the countdown timer bank
// no dependencies
package ctb_pkg;

  localparam int CMD_W       = 3;
  localparam int ID_W        = 6;
  localparam int DUR_W       = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_PAUSE  = 3'd1,
    CMD_RESUME = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_TICK   = 3'd4,
    CMD_SCAN   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

// ===== src/countdown_timer_bank.sv =====
// countdown_timer_bank: start, pause, resume, query and unknown commands give their
// result in the output register in the cycle after the transaction; tick and scan sweep
// every timer through one shared decrement / zero-compare unit, one timer per cycle,
// and give their result from the DONE state once the output register is free.
// one command at a time: in_tready stays low during a tick or scan and while the output is held.
// rst_n is synchronous; it clears counters (through per-entry loaded bits) and marks.
`include "countdown_timer_bank_assert.svh"
module countdown_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ctb_pkg::IN_TDATA_W-1:0]    in_tdata,  // command, timer_id, duration
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctb_pkg::OUT_TDATA_W-1:0]   out_tdata  // expired, id_in_range
);

  localparam int IDX_W = $clog2(NUM_TIMERS > 1 ? NUM_TIMERS : 2);
  localparam logic [ctb_pkg::ID_W:0] ID_LIM = (ctb_pkg::ID_W + 1)'(NUM_TIMERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  ctb_pkg::state_t state_r, state_nxt;
  ctb_pkg::cmd_t   cmd;

  logic [ctb_pkg::ID_W-1:0]  in_id;
  logic [ctb_pkg::DUR_W-1:0] in_dur;
  logic [IDX_W-1:0]          idx;
  logic                      id_ok;
  logic                      in_acc;
  logic                      is_sweep_cmd;
  logic                      out_free;
  logic                      done_load;

  logic [IDX_W-1:0] sweep_idx_r, sweep_idx_nxt;
  logic             wb_vld_r;
  logic [IDX_W-1:0] wb_idx_r;
  logic             is_tick_r, is_tick_nxt;
  logic             sweep_ok_r, sweep_ok_nxt;

  logic [NUM_TIMERS-1:0] expired_r, expired_nxt;
  logic [NUM_TIMERS-1:0] paused_r, paused_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_exp_r, out_exp_nxt;
  logic out_rng_r, out_rng_nxt;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic [ctb_pkg::DUR_W-1:0] wr_data;
  logic [ctb_pkg::DUR_W-1:0] rd_cnt;
  logic                      cnt_zero;
  logic [ctb_pkg::DUR_W-1:0] cnt_dec;
  logic                      tick_wr;

  assign cmd    = ctb_pkg::cmd_t'(in_tdata[ctb_pkg::CMD_W-1:0]);
  assign in_id  = in_tdata[ctb_pkg::CMD_W +: ctb_pkg::ID_W];
  assign in_dur = in_tdata[ctb_pkg::CMD_W + ctb_pkg::ID_W +: ctb_pkg::DUR_W];
  assign idx    = in_id[IDX_W-1:0];
  assign id_ok  = {1'b0, in_id} < ID_LIM;
  assign is_sweep_cmd = (cmd == ctb_pkg::CMD_TICK) || (cmd == ctb_pkg::CMD_SCAN);
  assign out_free = !out_valid_r || out_tready;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctb_pkg::ST_IDLE: begin
        if (in_acc && is_sweep_cmd) begin
          state_nxt = ctb_pkg::ST_SWEEP;
        end
      end
      ctb_pkg::ST_SWEEP: begin
        if (sweep_idx_r == LAST_IDX) begin
          state_nxt = ctb_pkg::ST_DONE;
        end
      end
      ctb_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ctb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ctb_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    done_load = 1'b0;
    unique case (state_r)
      ctb_pkg::ST_IDLE:  in_tready = out_free;
      ctb_pkg::ST_SWEEP: ;
      ctb_pkg::ST_DONE:  done_load = out_free;
      default: ;
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  // sweep index and write-back stage behind the registered memory read
  always_comb begin
    sweep_idx_nxt = '0;
    if (state_r == ctb_pkg::ST_SWEEP && sweep_idx_r != LAST_IDX) begin
      sweep_idx_nxt = sweep_idx_r + 1'b1;
    end
    is_tick_nxt  = is_tick_r;
    sweep_ok_nxt = sweep_ok_r;
    if (in_acc) begin
      is_tick_nxt  = (cmd == ctb_pkg::CMD_TICK);
      sweep_ok_nxt = id_ok;
    end
  end

  // shared decrement and zero-compare unit
  assign cnt_zero = (rd_cnt == '0);
  assign cnt_dec  = rd_cnt - 1'b1;
  assign tick_wr  = wb_vld_r && is_tick_r && !paused_r[wb_idx_r] && !cnt_zero;

  always_comb begin
    if (in_acc && cmd == ctb_pkg::CMD_START && id_ok) begin
      wr_en   = 1'b1;
      wr_idx  = idx;
      wr_data = in_dur;
    end else begin
      wr_en   = tick_wr;
      wr_idx  = wb_idx_r;
      wr_data = cnt_dec;
    end
  end

  ctb_cnt_mem #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_cnt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (sweep_idx_r),
    .rd_data (rd_cnt)
  );

  // marks and single-timer commands
  always_comb begin
    expired_nxt = expired_r;
    paused_nxt  = paused_r;
    if (wb_vld_r && !is_tick_r && cnt_zero) begin
      expired_nxt[wb_idx_r] = 1'b1;
    end
    if (in_acc && id_ok) begin
      unique case (cmd)
        ctb_pkg::CMD_START: begin
          expired_nxt[idx] = 1'b0;
          paused_nxt[idx]  = 1'b0;
        end
        ctb_pkg::CMD_PAUSE:  paused_nxt[idx] = 1'b1;
        ctb_pkg::CMD_RESUME: paused_nxt[idx] = 1'b0;
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_exp_nxt   = out_exp_r;
    out_rng_nxt   = out_rng_r;
    if (in_acc && !is_sweep_cmd) begin
      out_valid_nxt = 1'b1;
      out_exp_nxt   = (cmd == ctb_pkg::CMD_QUERY) && id_ok && expired_r[idx];
      out_rng_nxt   = id_ok;
    end else if (done_load) begin
      out_valid_nxt = 1'b1;
      out_exp_nxt   = 1'b0;
      out_rng_nxt   = sweep_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctb_pkg::ST_IDLE;
      sweep_idx_r <= '0;
      wb_vld_r    <= 1'b0;
      expired_r   <= '0;
      paused_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_idx_r <= sweep_idx_nxt;
      wb_vld_r    <= (state_r == ctb_pkg::ST_SWEEP);
      expired_r   <= expired_nxt;
      paused_r    <= paused_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r   <= sweep_idx_r;
    is_tick_r  <= is_tick_nxt;
    sweep_ok_r <= sweep_ok_nxt;
    out_exp_r  <= out_exp_nxt;
    out_rng_r  <= out_rng_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ctb_pkg::OUT_TDATA_W - 2){1'b0}}, out_rng_r, out_exp_r};

  `CTB_ASSERT(a_wb_not_idle, clk, rst_n, wb_vld_r |-> state_r != ctb_pkg::ST_IDLE)
  `CTB_ASSERT(a_rd_wr_apart, clk, rst_n, (wb_vld_r && state_r == ctb_pkg::ST_SWEEP) |-> wb_idx_r != sweep_idx_r)
  `CTB_ASSERT(a_sweep_starts, clk, rst_n, (in_acc && is_sweep_cmd) |=> state_r == ctb_pkg::ST_SWEEP && sweep_idx_r == '0)
  `CTB_ASSERT(a_done_gives_result, clk, rst_n, done_load |=> out_tvalid)
  `CTB_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != ctb_pkg::ST_IDLE) |-> !in_tready)

endmodule

// ===== src/ctb_cnt_mem.sv =====
// counter memory of the timer bank: one write port, one registered read port
// per-entry loaded bits make unwritten entries read as zero; uses ctb_pkg
module ctb_cnt_mem #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(NUM_TIMERS > 1 ? NUM_TIMERS : 2)-1:0] wr_idx,
  input  logic [ctb_pkg::DUR_W-1:0]     wr_data,
  input  logic [$clog2(NUM_TIMERS > 1 ? NUM_TIMERS : 2)-1:0] rd_idx,
  output logic [ctb_pkg::DUR_W-1:0]     rd_data
);

  logic [ctb_pkg::DUR_W-1:0] mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]     loaded_r;
  logic [NUM_TIMERS-1:0]     loaded_nxt;
  logic [ctb_pkg::DUR_W-1:0] rd_q_r;
  logic                      rd_ld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q_r <= mem[rd_idx];
  end

  always_comb begin
    loaded_nxt = loaded_r;
    if (wr_en) begin
      loaded_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      rd_ld_r  <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
      rd_ld_r  <= loaded_r[rd_idx];
    end
  end

  // entry never written since reset reads as zero
  assign rd_data = rd_ld_r ? rd_q_r : '0;

endmodule
